@@ design/msre_pkg.sv @@
`timescale 1ns / 1ps

package msre_pkg;

  localparam int STORE_MAX = 16;

  localparam logic CMD_READ  = 1'b0;
  localparam logic CMD_WRITE = 1'b1;

  localparam logic [31:0] IDX_EFER          = 32'hC000_0080;
  localparam logic [31:0] IDX_PAT           = 32'h0000_0277;
  localparam logic [31:0] IDX_MISC_ENABLE   = 32'h0000_01A0;
  localparam logic [31:0] IDX_PLATFORM_INFO = 32'h0000_00CE;
  localparam logic [31:0] IDX_TURBO0        = 32'h0000_01AD;
  localparam logic [31:0] IDX_TURBO1        = 32'h0000_01AE;
  localparam logic [31:0] IDX_UCODE_UPDATE  = 32'h0000_0079;

  localparam logic [31:0] IDX_MCG_STATUS    = 32'h0000_017A;
  localparam logic [31:0] IDX_MCG_CAP       = 32'h0000_0179;
  localparam logic [31:0] IDX_MTRR_DEF_TYPE = 32'h0000_02FF;
  localparam logic [31:0] IDX_MTRR_FIX4K_LO = 32'h0000_0268;
  localparam logic [31:0] IDX_MTRR_FIX4K_HI = 32'h0000_026F;
  localparam logic [31:0] IDX_MTRR_FIX16K_0 = 32'h0000_0258;
  localparam logic [31:0] IDX_MTRR_FIX16K_1 = 32'h0000_0259;
  localparam logic [31:0] IDX_MTRR_FIX64K   = 32'h0000_0250;
  localparam logic [31:0] IDX_UCODE_SIGN    = 32'h0000_008B;

  localparam logic [31:0] IDX_MTRR_CAP      = 32'h0000_00FE;
  localparam logic [31:0] IDX_PLATFORM_ID   = 32'h0000_0017;
  localparam logic [31:0] IDX_PKG_ENERGY    = 32'h0000_0611;
  localparam logic [31:0] IDX_PP0_ENERGY    = 32'h0000_0639;
  localparam logic [31:0] IDX_PP1_ENERGY    = 32'h0000_0641;
  localparam logic [31:0] IDX_DRAM_ENERGY   = 32'h0000_0619;

  localparam logic [63:0] PAT_RESET  = 64'h0007_0406_0007_0406;
  localparam logic [63:0] MISC_VALUE = 64'h1 | (64'h1 << 12) | (64'h1 << 11);

  typedef struct packed {
    logic efer_we;
    logic pat_we;
  } msre_wr_t;

  function automatic logic common_ignored(input logic [31:0] i);
    return i == IDX_MCG_CAP || i == IDX_MCG_STATUS || i == IDX_MTRR_DEF_TYPE ||
           (i >= IDX_MTRR_FIX4K_LO && i <= IDX_MTRR_FIX4K_HI) ||
           i == IDX_MTRR_FIX16K_0 || i == IDX_MTRR_FIX16K_1 ||
           i == IDX_MTRR_FIX64K || i == IDX_UCODE_SIGN;
  endfunction

  function automatic logic reads_zero(input logic [31:0] i);
    return common_ignored(i) || i == IDX_MTRR_CAP || i == IDX_PLATFORM_ID ||
           i == IDX_PKG_ENERGY || i == IDX_PP0_ENERGY ||
           i == IDX_PP1_ENERGY || i == IDX_DRAM_ENERGY;
  endfunction

  function automatic logic pat_ok(input logic [63:0] v);
    logic ok;
    logic [7:0] b;
    ok = 1'b1;
    for (int k = 0; k < 8; k++) begin
      b = v[k*8 +: 8];
      if (b[7:3] != 5'd0 || b[2:1] == 2'b01) begin
        ok = 1'b0;
      end
    end
    return ok;
  endfunction

endpackage

@@ design/msre_if.sv @@
`timescale 1ns / 1ps

interface msre_req_if;
  logic        valid;
  logic        ready;
  logic        cmd;
  logic [3:0]  cpu_id;
  logic [31:0] msr_index;
  logic [63:0] write_data;

  modport source (output valid, cmd, cpu_id, msr_index, write_data, input ready);
  modport sink (input valid, cmd, cpu_id, msr_index, write_data, output ready);
endinterface

interface msre_rsp_if;
  logic        valid;
  logic        ready;
  logic        status;
  logic [31:0] read_low;
  logic [31:0] read_high;

  modport source (output valid, status, read_low, read_high, input ready);
  modport sink (input valid, status, read_low, read_high, output ready);
endinterface

@@ design/msre_cpu_store.sv @@
`timescale 1ns / 1ps

module msre_cpu_store #(
  parameter int DEPTH = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  msre_pkg::msre_wr_t  wr,
  input  logic [3:0]          cpu_id,
  input  logic [63:0]         wdata,
  output logic [63:0]         efer_rd,
  output logic [63:0]         pat_rd
);
  import msre_pkg::*;

  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [63:0] efer [DEPTH];
  logic [63:0] pat  [DEPTH];
  logic [IDX_W-1:0] addr;

  assign addr = cpu_id[IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < DEPTH; k++) begin
        efer[k] <= 64'd0;
        pat[k]  <= PAT_RESET;
      end
    end else begin
      if (wr.efer_we) begin
        efer[addr] <= wdata;
      end
      if (wr.pat_we) begin
        pat[addr] <= wdata;
      end
    end
  end

  assign efer_rd = efer[addr];
  assign pat_rd  = pat[addr];

endmodule

@@ design/msre_decode.sv @@
`timescale 1ns / 1ps

module msre_decode (
  input  logic               cmd,
  input  logic               cpu_ok,
  input  logic [31:0]        msr_index,
  input  logic [63:0]        write_data,
  input  logic [7:0]         clock_ratio,
  input  logic [63:0]        efer_rd,
  input  logic [63:0]        pat_rd,
  output logic               stop,
  output logic [63:0]        value,
  output msre_pkg::msre_wr_t wr
);
  import msre_pkg::*;

  always_comb begin
    stop  = 1'b0;
    value = 64'd0;
    wr    = '0;
    if (cmd == CMD_READ) begin
      if (msr_index == IDX_EFER) begin
        value = cpu_ok ? efer_rd : 64'd0;
      end else if (reads_zero(msr_index)) begin
        value = 64'd0;
      end else if (msr_index == IDX_MISC_ENABLE) begin
        value = MISC_VALUE;
      end else if (msr_index == IDX_PLATFORM_INFO) begin
        value = {16'd0, clock_ratio, 24'd0, clock_ratio, 8'd0};
      end else if (msr_index == IDX_TURBO0 || msr_index == IDX_TURBO1) begin
        value = {8{clock_ratio}};
      end else if (msr_index == IDX_PAT) begin
        value = cpu_ok ? pat_rd : 64'd0;
      end else begin
        stop = 1'b1;
      end
    end else begin
      if (msr_index == IDX_EFER) begin
        wr.efer_we = cpu_ok;
      end else if (common_ignored(msr_index) || msr_index == IDX_UCODE_UPDATE) begin
        stop = 1'b0;
      end else if (msr_index == IDX_PAT) begin
        if (pat_ok(write_data)) begin
          wr.pat_we = cpu_ok;
        end else begin
          stop = 1'b1;
        end
      end else begin
        stop = 1'b1;
      end
    end
  end

endmodule

@@ design/msr_access_emulator.sv @@
`timescale 1ns / 1ps
// MSR access emulator for guest RDMSR / WRMSR.
// req (sink): one access per request: cmd (0 read, 1 write), cpu_id, msr_index,
//   write_data. Accepted when req.valid and req.ready are both high.
// rsp (source): one result per request: status (1 = stop on unknown index or
//   invalid PAT), read_low / read_high halves of the read value (zero on writes
//   and stops). Results come out in request order.
// cfg_wr_en / cfg_wr_data: write clock_ratio at a clock edge with cfg_wr_en high;
//   write only while no request is in flight.
// Pipeline: the request lands in the input register when accepted; rsp.valid rises
//   when the result register loads from it, once that register is empty or taken.
//   Throughput: one request per cycle while results are taken; the decode and
//   the per-CPU EFER / PAT update sit in one pass between the two registers.
// Reset (rst, synchronous): clears both pipeline stages, EFER to zero, PAT to its
//   power-on value in every CPU entry, and clock_ratio to zero.
// Stall: while rsp.ready is low the result holds, one more request is taken into
//   the input register, and req.ready then drops until the result is taken.
module msr_access_emulator #(
  parameter int CPU_COUNT = 16
) (
  input  logic          clk,
  input  logic          rst,
  msre_req_if.sink      req,
  msre_rsp_if.source    rsp,
  input  logic          cfg_wr_en,
  input  logic [7:0]    cfg_wr_data
);
  import msre_pkg::*;

  localparam int STORE_DEPTH = (CPU_COUNT < STORE_MAX) ? CPU_COUNT : STORE_MAX;
  localparam logic [8:0] CPU_LIMIT = 9'(CPU_COUNT);

  logic        s1_valid;
  logic        s1_cmd;
  logic [3:0]  s1_cpu_id;
  logic [31:0] s1_msr_index;
  logic [63:0] s1_write_data;
  logic [7:0]  clock_ratio;

  logic        s1_advance;
  logic        cpu_ok;
  logic        stop;
  logic [63:0] value;
  logic [63:0] efer_rd;
  logic [63:0] pat_rd;
  msre_wr_t    wr_dec;
  msre_wr_t    wr;

  assign s1_advance = s1_valid && (!rsp.valid || rsp.ready);
  assign req.ready  = !s1_valid || s1_advance;
  assign cpu_ok     = {5'd0, s1_cpu_id} < CPU_LIMIT;
  assign wr.efer_we = wr_dec.efer_we && s1_advance;
  assign wr.pat_we  = wr_dec.pat_we && s1_advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      clock_ratio <= 8'd0;
    end else if (cfg_wr_en) begin
      clock_ratio <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (req.ready) begin
      s1_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      s1_cmd        <= req.cmd;
      s1_cpu_id     <= req.cpu_id;
      s1_msr_index  <= req.msr_index;
      s1_write_data <= req.write_data;
    end
  end

  msre_cpu_store #(
    .DEPTH(STORE_DEPTH)
  ) u_store (
    .clk     (clk),
    .rst     (rst),
    .wr      (wr),
    .cpu_id  (s1_cpu_id),
    .wdata   (s1_write_data),
    .efer_rd (efer_rd),
    .pat_rd  (pat_rd)
  );

  msre_decode u_decode (
    .cmd         (s1_cmd),
    .cpu_ok      (cpu_ok),
    .msr_index   (s1_msr_index),
    .write_data  (s1_write_data),
    .clock_ratio (clock_ratio),
    .efer_rd     (efer_rd),
    .pat_rd      (pat_rd),
    .stop        (stop),
    .value       (value),
    .wr          (wr_dec)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (!rsp.valid || rsp.ready) begin
      rsp.valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance) begin
      rsp.status    <= stop;
      rsp.read_low  <= value[31:0];
      rsp.read_high <= value[63:32];
    end
  end

`ifndef ASSERT_OFF
  a_stop_zero: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.status |-> rsp.read_low == 32'd0 && rsp.read_high == 32'd0)
    else $error("stop result carries read data");

  a_single_store_write: assert property (@(posedge clk) disable iff (rst)
    !(wr.efer_we && wr.pat_we))
    else $error("EFER and PAT written by one request");

  a_write_on_advance: assert property (@(posedge clk) disable iff (rst)
    (wr.efer_we || wr.pat_we) |-> s1_advance && s1_cmd == CMD_WRITE)
    else $error("store written without a write request advancing");

  a_ready_low_full: assert property (@(posedge clk) disable iff (rst)
    !req.ready |-> s1_valid && rsp.valid && !rsp.ready)
    else $error("request blocked while pipeline has room");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !s1_valid && !rsp.valid)
    else $error("pipeline not empty after reset");
`endif

endmodule
